// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition a at an edge requires condition b at the same edge
`define SFD_ASSERT_NOW(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion violated");

// condition a at an edge requires condition b at the next edge
`define SFD_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion violated");

`else

`define SFD_ASSERT_NOW(lbl, clk, rst, a, b)
`define SFD_ASSERT_NEXT(lbl, clk, rst, a, b)

`endif

`endif

// ----- hdl/sfd_pkg.sv -----
`default_nettype none

package sfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned IDX_W  = 2;

  // event codes
  localparam logic [EV_W-1:0] EV_DISCARD = 3'd0;
  localparam logic [EV_W-1:0] EV_HEADER  = 3'd1;
  localparam logic [EV_W-1:0] EV_COMMAND = 3'd2;
  localparam logic [EV_W-1:0] EV_PAYLOAD = 3'd3;
  localparam logic [EV_W-1:0] EV_BADLEN  = 3'd4;
  localparam logic [EV_W-1:0] EV_FAULT   = 3'd5;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SHORT_START = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG_START  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SHORT_LIMIT = 2'd2;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_SHORT_START = 8'd254;
  localparam logic [BYTE_W-1:0] RST_LONG_START  = 8'd253;
  localparam logic [BYTE_W-1:0] RST_SHORT_LIMIT = 8'd250;

  // header offsets after the start byte and each length byte
  localparam logic [LEN_W-1:0] POS_AFTER_START = 16'd1;
  localparam logic [LEN_W-1:0] POS_AFTER_LEN1  = 16'd2;
  localparam logic [LEN_W-1:0] POS_AFTER_LEN2  = 16'd3;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_LEN1 = 5'b00010,
    PH_LEN2 = 5'b00100,
    PH_CMD  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] short_start;
    logic [BYTE_W-1:0] long_start;
    logic [BYTE_W-1:0] short_limit;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              read_fault;
  } item_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] command_type;
    logic [LEN_W-1:0]  frame_length;
    logic [LEN_W-1:0]  byte_position;
    logic              frame_last;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/sfd_in_if.sv -----
`default_nettype none

interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       read_fault;

  modport source(output valid, output rx_byte, output read_fault, input ready);
  modport sink(input valid, input rx_byte, input read_fault, output ready);
endinterface

`default_nettype wire

// ----- hdl/sfd_out_if.sv -----
`default_nettype none

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  command_type;
  logic [15:0] frame_length;
  logic [15:0] byte_position;
  logic        frame_last;

  modport source(output valid, output event_res, output data_byte, output command_type,
                 output frame_length, output byte_position, output frame_last,
                 input ready);
  modport sink(input valid, input event_res, input data_byte, input command_type,
               input frame_length, input byte_position, input frame_last,
               output ready);
endinterface

`default_nettype wire

// ----- hdl/sfd_cfg_regs.sv -----
`default_nettype none

module sfd_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [sfd_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [sfd_pkg::BYTE_W-1:0] cfg_data,
  output sfd_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_start <= sfd_pkg::RST_SHORT_START;
      cfg.long_start  <= sfd_pkg::RST_LONG_START;
      cfg.short_limit <= sfd_pkg::RST_SHORT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        sfd_pkg::REG_SHORT_START: cfg.short_start <= cfg_data;
        sfd_pkg::REG_LONG_START:  cfg.long_start  <= cfg_data;
        sfd_pkg::REG_SHORT_LIMIT: cfg.short_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfd_core.sv -----
`default_nettype none
`include "assert_macros.svh"

module sfd_core (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire sfd_pkg::cfg_t  cfg,
  input  wire logic  advance,
  input  wire sfd_pkg::item_t item,
  output sfd_pkg::res_t  res
);

  sfd_pkg::phase_t                 phase, phase_next;
  logic                            long_frame, long_frame_next;
  logic [sfd_pkg::LEN_W-1:0]       length_so_far, length_so_far_next;
  logic [sfd_pkg::LEN_W-1:0]       position, position_next;
  logic [sfd_pkg::BYTE_W-1:0]      current_command, current_command_next;
  logic [sfd_pkg::BYTE_W-1:0]      b;
  logic                            last;

  assign b = item.rx_byte;

  // last byte when the next offset reaches the total length
  assign last = ({1'b0, position} + 17'd1) >= {1'b0, length_so_far};

  always_comb begin
    phase_next           = phase;
    long_frame_next      = long_frame;
    length_so_far_next   = length_so_far;
    position_next        = position;
    current_command_next = current_command;
    res                  = '0;

    if (item.read_fault) begin
      phase_next    = sfd_pkg::PH_HUNT;
      position_next = '0;
      res.event_res = sfd_pkg::EV_FAULT;
    end else begin
      case (phase)
        sfd_pkg::PH_LEN1: begin
          res.data_byte     = b;
          res.byte_position = position;
          if (!long_frame && (b >= cfg.short_limit)) begin
            phase_next    = sfd_pkg::PH_HUNT;
            position_next = '0;
            res.event_res = sfd_pkg::EV_BADLEN;
          end else begin
            if (long_frame) begin
              length_so_far_next = {b, 8'h00};
              phase_next         = sfd_pkg::PH_LEN2;
            end else begin
              length_so_far_next = {8'h00, b};
              phase_next         = sfd_pkg::PH_CMD;
            end
            position_next    = sfd_pkg::POS_AFTER_LEN1;
            res.event_res    = sfd_pkg::EV_HEADER;
            res.frame_length = length_so_far_next;
          end
        end
        sfd_pkg::PH_LEN2: begin
          length_so_far_next = length_so_far + {8'h00, b};
          phase_next         = sfd_pkg::PH_CMD;
          position_next      = sfd_pkg::POS_AFTER_LEN2;
          res.event_res      = sfd_pkg::EV_HEADER;
          res.data_byte      = b;
          res.frame_length   = length_so_far_next;
          res.byte_position  = position;
        end
        sfd_pkg::PH_CMD, sfd_pkg::PH_DATA: begin
          if (phase == sfd_pkg::PH_CMD) begin
            current_command_next = b;
            res.event_res        = sfd_pkg::EV_COMMAND;
          end else begin
            res.event_res        = sfd_pkg::EV_PAYLOAD;
          end
          if (last) begin
            phase_next    = sfd_pkg::PH_HUNT;
            position_next = '0;
          end else begin
            phase_next    = sfd_pkg::PH_DATA;
            position_next = position + 16'd1;
          end
          res.data_byte     = b;
          res.command_type  = current_command_next;
          res.frame_length  = length_so_far;
          res.byte_position = position;
          res.frame_last    = last;
        end
        default: begin
          res.data_byte = b;
          if ((b == cfg.long_start) || (b == cfg.short_start)) begin
            long_frame_next    = (b == cfg.long_start);
            length_so_far_next = '0;
            position_next      = sfd_pkg::POS_AFTER_START;
            phase_next         = sfd_pkg::PH_LEN1;
            res.event_res      = sfd_pkg::EV_HEADER;
          end else begin
            phase_next    = sfd_pkg::PH_HUNT;
            position_next = '0;
            res.event_res = sfd_pkg::EV_DISCARD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= sfd_pkg::PH_HUNT;
      long_frame      <= 1'b0;
      length_so_far   <= '0;
      position        <= '0;
      current_command <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      long_frame      <= long_frame_next;
      length_so_far   <= length_so_far_next;
      position        <= position_next;
      current_command <= current_command_next;
    end
  end

  `SFD_ASSERT_NEXT(a_fault_to_hunt, clk, rst, advance && item.read_fault,
                   (phase == sfd_pkg::PH_HUNT) && (position == '0))
  `SFD_ASSERT_NOW(a_hunt_pos_zero, clk, rst, phase == sfd_pkg::PH_HUNT, position == '0)

endmodule

`default_nettype wire

// ----- hdl/serial_frame_deframer.sv -----
// Serial frame deframer: takes one received byte per item on byte_ch and gives one
// result item per byte on event_ch, describing how the byte was consumed (discarded,
// start or length byte, command byte, payload byte, bad short length, or read error),
// together with the frame's command, total length, the byte's offset in the frame and a
// last-of-frame flag. A frame is a start byte (short or long), a one-byte or two-byte
// big-endian length that counts the whole frame including header, a command byte and
// payload. Throughput is one item per clock cycle while the receiver is ready. An
// accepted byte lands in the input register, where the whole per-byte state update is
// done; its result item then waits in the result register until the receiver takes it.
// Configuration registers (short start byte, long start byte, short length limit) are
// written through cfg_we/cfg_index/cfg_data and should be changed only while no item
// is in flight.
`default_nettype none
`include "assert_macros.svh"

module serial_frame_deframer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [sfd_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [sfd_pkg::BYTE_W-1:0] cfg_data,
  sfd_in_if.sink                         byte_ch,
  sfd_out_if.source                      event_ch
);

  sfd_pkg::cfg_t  cfg;
  sfd_pkg::item_t in_item;
  sfd_pkg::res_t  core_res;
  sfd_pkg::res_t  out_res;
  logic           in_valid;
  logic           out_valid;
  logic           advance;

  // register block
  sfd_cfg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // an item moves from the input register to the result register when the result
  // register is empty or being emptied in the same cycle
  assign advance       = in_valid && (!out_valid || event_ch.ready);
  assign byte_ch.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      in_valid <= byte_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      in_item.rx_byte    <= byte_ch.rx_byte;
      in_item.read_fault <= byte_ch.read_fault;
    end
  end

  // framing state and per-byte decode
  sfd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (in_item),
    .res     (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (event_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign event_ch.valid         = out_valid;
  assign event_ch.event_res     = out_res.event_res;
  assign event_ch.data_byte     = out_res.data_byte;
  assign event_ch.command_type  = out_res.command_type;
  assign event_ch.frame_length  = out_res.frame_length;
  assign event_ch.byte_position = out_res.byte_position;
  assign event_ch.frame_last    = out_res.frame_last;

  // a decoded byte always shows up as a result in the next cycle
  `SFD_ASSERT_NEXT(a_advance_to_out, clk, rst, advance, out_valid)
  // a held input item is never dropped
  `SFD_ASSERT_NEXT(a_in_held, clk, rst, in_valid && !advance, in_valid)
  // only command or payload bytes can close a frame
  `SFD_ASSERT_NOW(a_last_kind, clk, rst, out_valid && out_res.frame_last,
                  (out_res.event_res == sfd_pkg::EV_COMMAND) ||
                  (out_res.event_res == sfd_pkg::EV_PAYLOAD))

endmodule

`default_nettype wire
